@@ src/c8cpu_pkg.sv @@
package c8cpu_pkg;

    localparam int ADDR_W        = 12;
    localparam int MEM_DEPTH     = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int FONT_LEN      = 80;
    localparam int S_DATA_W      = 48;
    localparam int M_DATA_W      = 96;

    localparam logic [ADDR_W-1:0] FONT_BASE  = 12'h050;
    localparam logic [ADDR_W-1:0] FONT_END   = FONT_BASE + 12'(FONT_LEN);
    localparam logic [ADDR_W-1:0] RESET_PC   = 12'h200;
    localparam logic [ADDR_W-1:0] ADDR_LAST  = 12'(MEM_DEPTH - 1);
    localparam logic [SP_W-1:0]   SP_LAST    = SP_W'(STACK_DEPTH - 1);

    localparam logic [7:0] GLYPHS [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [1:0] {
        OPR_WRITE = 2'd0,
        OPR_EXEC  = 2'd1,
        OPR_READ  = 2'd2,
        OPR_NONE  = 2'd3
    } opr_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_MEMWR, ST_ROWRD, ST_FETCH_HI, ST_FETCH_LO,
        ST_RDX, ST_RDY, ST_RD0, ST_EXEC, ST_WRX, ST_CLS, ST_DR_RD, ST_DR_WR,
        ST_DR_VF, ST_BCD, ST_ST_RD, ST_ST_WR, ST_LD_RD, ST_LD_WR, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        UOP_NONE, UOP_CLR, UOP_MEMWR, UOP_ROWRD, UOP_FETCH_HI, UOP_FETCH_LO,
        UOP_RDX, UOP_RDY, UOP_RD0, UOP_EXEC, UOP_WRX, UOP_CLS, UOP_DR_RD,
        UOP_DR_WR, UOP_DR_VF, UOP_BCD, UOP_ST_RD, UOP_ST_WR, UOP_LD_RD,
        UOP_LD_WR, UOP_DONE
    } uop_t;

    typedef enum logic [2:0] {
        K_SIMPLE, K_WRX, K_CLS, K_DRAW, K_BCD, K_STORE, K_LOAD
    } kind_t;

    typedef struct packed {
        uop_t uop;
        logic accept;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  n_zero;
        logic  cnt_at_x;
        logic  cnt_at_n1;
        logic  cnt_at_2;
        logic  cnt_at_31;
        logic  cnt_at_top;
        logic  out_busy;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && a < FONT_END) begin
            return GLYPHS[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

@@ src/c8cpu_ctrl.sv @@
module c8cpu_ctrl import c8cpu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    input  stat_t      stat,
    output logic       s_tready,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (stat.cnt_at_top) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (opr_t'(s_tuser))
                        OPR_WRITE: state_next = ST_MEMWR;
                        OPR_EXEC:  state_next = ST_FETCH_HI;
                        OPR_READ:  state_next = ST_ROWRD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_MEMWR:    state_next = ST_DONE;
            ST_ROWRD:    state_next = ST_DONE;
            ST_FETCH_HI: state_next = ST_FETCH_LO;
            ST_FETCH_LO: state_next = ST_RDX;
            ST_RDX:      state_next = ST_RDY;
            ST_RDY:      state_next = ST_RD0;
            ST_RD0:      state_next = ST_EXEC;
            ST_EXEC: begin
                case (stat.kind)
                    K_WRX:   state_next = ST_WRX;
                    K_CLS:   state_next = ST_CLS;
                    K_DRAW:  state_next = stat.n_zero ? ST_DR_VF : ST_DR_RD;
                    K_BCD:   state_next = ST_BCD;
                    K_STORE: state_next = ST_ST_RD;
                    K_LOAD:  state_next = ST_LD_RD;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_WRX:   state_next = ST_DONE;
            ST_CLS:   if (stat.cnt_at_31) state_next = ST_DONE;
            ST_DR_RD: state_next = ST_DR_WR;
            ST_DR_WR: state_next = stat.cnt_at_n1 ? ST_DR_VF : ST_DR_RD;
            ST_DR_VF: state_next = ST_DONE;
            ST_BCD:   if (stat.cnt_at_2) state_next = ST_DONE;
            ST_ST_RD: state_next = ST_ST_WR;
            ST_ST_WR: state_next = stat.cnt_at_x ? ST_DONE : ST_ST_RD;
            ST_LD_RD: state_next = ST_LD_WR;
            ST_LD_WR: state_next = stat.cnt_at_x ? ST_DONE : ST_LD_RD;
            ST_DONE:  if (!stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
        case (state_reg)
            ST_CLEAR:    cmd.uop = UOP_CLR;
            ST_MEMWR:    cmd.uop = UOP_MEMWR;
            ST_ROWRD:    cmd.uop = UOP_ROWRD;
            ST_FETCH_HI: cmd.uop = UOP_FETCH_HI;
            ST_FETCH_LO: cmd.uop = UOP_FETCH_LO;
            ST_RDX:      cmd.uop = UOP_RDX;
            ST_RDY:      cmd.uop = UOP_RDY;
            ST_RD0:      cmd.uop = UOP_RD0;
            ST_EXEC:     cmd.uop = UOP_EXEC;
            ST_WRX:      cmd.uop = UOP_WRX;
            ST_CLS:      cmd.uop = UOP_CLS;
            ST_DR_RD:    cmd.uop = UOP_DR_RD;
            ST_DR_WR:    cmd.uop = UOP_DR_WR;
            ST_DR_VF:    cmd.uop = UOP_DR_VF;
            ST_BCD:      cmd.uop = UOP_BCD;
            ST_ST_RD:    cmd.uop = UOP_ST_RD;
            ST_ST_WR:    cmd.uop = UOP_ST_WR;
            ST_LD_RD:    cmd.uop = UOP_LD_RD;
            ST_LD_WR:    cmd.uop = UOP_LD_WR;
            ST_DONE:     cmd.uop = stat.out_busy ? UOP_NONE : UOP_DONE;
            default:     cmd.uop = UOP_NONE;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg != ST_IDLE)
        else $error("accepted word did not start work");

    a_clear_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !stat.cnt_at_top) |=> state_reg == ST_CLEAR)
        else $error("clearing pass ended early");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && stat.out_busy) |=> state_reg == ST_DONE)
        else $error("result dropped while output busy");

    a_done_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !stat.out_busy) |=> state_reg == ST_IDLE)
        else $error("done did not return to idle");

endmodule

@@ src/c8cpu_dpath.sv @@
module c8cpu_dpath import c8cpu_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    input  logic [1:0]              s_tuser,
    input  logic [S_DATA_W-1:0]     s_tdata,
    input  logic                    m_tready,
    input  logic                    cfg_we,
    input  logic [ADDR_W-1:0]       cfg_data,
    output stat_t                   stat,
    output logic                    m_tvalid,
    output logic [SCREEN_WIDTH-1:0] out_row,
    output logic [ADDR_W-1:0]       out_pc,
    output logic [15:0]             out_opcode,
    output logic                    out_sound,
    output logic                    out_wait,
    output logic                    out_changed
);

    logic [7:0]              mem_array [MEM_DEPTH];
    logic [7:0]              vreg_array [16];
    logic [SCREEN_WIDTH-1:0] fb_array [SCREEN_HEIGHT];
    logic [ADDR_W-1:0]       stk_array [STACK_DEPTH];

    logic [ADDR_W-1:0] pc_reg, pc_next, i_reg, i_next, cnt_reg, cnt_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [7:0]        dt_reg, dt_next, st_reg, st_next;
    logic [15:0]       op_reg, op_next;
    logic [7:0]        va_reg, va_next, vb_reg, vb_next, res_reg, res_next;
    logic              hit_reg, hit_next, chg_reg, chg_next, wait_reg, wait_next;
    logic [SCREEN_WIDTH-1:0] row_reg, row_next;
    logic [1:0]        in_op_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [7:0]        in_wdata_reg, in_rnd_reg;
    logic [15:0]       in_keys_reg;
    logic [7:0]        mem_rd_reg, v_rd_reg;
    logic              m_valid_reg, m_valid_next;

    logic              mem_we, v_we, fb_we, stk_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, v_wdata;
    logic [3:0]        v_waddr, v_raddr;
    logic [ROW_W-1:0]  fb_widx, fb_ridx;
    logic [SCREEN_WIDTH-1:0] fb_wdata, fb_row;

    logic [3:0]  x, y, n, key_idx;
    logic [7:0]  kk, alu_res;
    logic        alu_flag, key_hit, key_any;
    logic [8:0]  sum9;
    logic [SP_W-1:0] sp_dec, sp_inc;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_hund, bcd_tens, bcd_ones;
    logic [7:0]  bcd_digit;
    logic [ADDR_W-1:0] i_off;
    logic [SCREEN_WIDTH-1:0]   spr_base, spr_mask;
    logic [2*SCREEN_WIDTH-1:0] spr_rot;
    logic        tick;

    assign x  = op_reg[11:8];
    assign y  = op_reg[7:4];
    assign n  = op_reg[3:0];
    assign kk = op_reg[7:0];
    assign sp_dec = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
    assign i_off  = i_reg + cnt_reg;
    assign fb_row = fb_array[fb_ridx];
    assign tick   = (opr_t'(in_op_reg) == OPR_EXEC);

    always_comb begin
        sum9     = {1'b0, va_reg} + {1'b0, vb_reg};
        alu_flag = 1'b0;
        alu_res  = va_reg;
        case (n)
            4'h4: begin alu_flag = sum9[8];           alu_res = sum9[7:0];       end
            4'h5: begin alu_flag = va_reg > vb_reg;   alu_res = va_reg - vb_reg; end
            4'h6: begin alu_flag = va_reg[0];         alu_res = va_reg >> 1;     end
            4'h7: begin alu_flag = vb_reg > va_reg;   alu_res = vb_reg - va_reg; end
            4'hE: begin alu_flag = va_reg[7];         alu_res = va_reg << 1;     end
            default: ;
        endcase
    end

    always_comb begin
        key_hit = (va_reg < 8'd16) && in_keys_reg[va_reg[3:0]];
        key_any = |in_keys_reg;
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (in_keys_reg[k]) key_idx = 4'(k);
        end
    end

    // decimal digits of vx
    always_comb begin
        if (va_reg >= 8'd200) begin
            bcd_hund = 4'd2;
            bcd_rem  = 7'(va_reg - 8'd200);
        end else if (va_reg >= 8'd100) begin
            bcd_hund = 4'd1;
            bcd_rem  = 7'(va_reg - 8'd100);
        end else begin
            bcd_hund = 4'd0;
            bcd_rem  = va_reg[6:0];
        end
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_tens = bcd_prod[14:11];
        bcd_ones = 4'(bcd_rem - 7'(bcd_tens) * 7'd10);
        case (cnt_reg[1:0])
            2'd0:    bcd_digit = {4'd0, bcd_hund};
            2'd1:    bcd_digit = {4'd0, bcd_tens};
            default: bcd_digit = {4'd0, bcd_ones};
        endcase
    end

    always_comb begin
        spr_base = {mem_rd_reg, {(SCREEN_WIDTH-8){1'b0}}};
        spr_rot  = {spr_base, spr_base} >> va_reg[COL_W-1:0];
        spr_mask = spr_rot[SCREEN_WIDTH-1:0];
    end

    always_comb begin
        stat.kind = K_SIMPLE;
        case (op_reg[15:12])
            4'h0: if (op_reg == 16'h00E0) stat.kind = K_CLS;
            4'h8: begin
                if (n == 4'h4 || n == 4'h5 || n == 4'h6 || n == 4'h7 || n == 4'hE) begin
                    stat.kind = K_WRX;
                end
            end
            4'hD: stat.kind = K_DRAW;
            4'hF: begin
                if (kk == 8'h33) stat.kind = K_BCD;
                else if (kk == 8'h55) stat.kind = K_STORE;
                else if (kk == 8'h65) stat.kind = K_LOAD;
            end
            default: ;
        endcase
        stat.n_zero     = (n == 4'd0);
        stat.cnt_at_x   = (cnt_reg[3:0] == x);
        stat.cnt_at_n1  = (cnt_reg[3:0] == n - 4'd1);
        stat.cnt_at_2   = (cnt_reg[1:0] == 2'd2);
        stat.cnt_at_31  = (cnt_reg[ROW_W-1:0] == ROW_W'(SCREEN_HEIGHT - 1));
        stat.cnt_at_top = (cnt_reg == ADDR_LAST);
        stat.out_busy   = m_valid_reg && !m_tready;
    end

    always_comb begin
        pc_next = pc_reg;   i_next = i_reg;     cnt_next = cnt_reg;
        sp_next = sp_reg;   dt_next = dt_reg;   st_next = st_reg;
        op_next = op_reg;   va_next = va_reg;   vb_next = vb_reg;
        res_next = res_reg; hit_next = hit_reg; chg_next = chg_reg;
        wait_next = wait_reg; row_next = row_reg;
        mem_we = 1'b0; mem_waddr = i_off; mem_wdata = 8'h00; mem_raddr = i_off;
        v_we = 1'b0; v_waddr = x; v_wdata = 8'h00; v_raddr = 4'd0;
        fb_we = 1'b0; fb_widx = cnt_reg[ROW_W-1:0]; fb_wdata = '0;
        fb_ridx = cnt_reg[ROW_W-1:0];
        stk_we = 1'b0;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;

        if (cmd.accept) begin
            op_next = 16'h0000; wait_next = 1'b0; chg_next = 1'b0; row_next = '0;
        end

        case (cmd.uop)
            UOP_CLR: begin
                mem_we = 1'b1; mem_waddr = cnt_reg; mem_wdata = font_byte(cnt_reg);
                v_we = 1'b1; v_waddr = cnt_reg[3:0];
                fb_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_MEMWR: begin
                mem_we = 1'b1; mem_waddr = in_addr_reg; mem_wdata = in_wdata_reg;
            end
            UOP_ROWRD: begin
                fb_ridx = in_addr_reg[ROW_W-1:0];
                row_next = fb_row;
            end
            UOP_FETCH_HI: mem_raddr = pc_reg;
            UOP_FETCH_LO: begin
                mem_raddr = pc_reg + 1'b1;
                op_next[15:8] = mem_rd_reg;
            end
            UOP_RDX: begin
                op_next[7:0] = mem_rd_reg;
                v_raddr = op_reg[11:8];
                pc_next = pc_reg + 12'd2;
            end
            UOP_RDY: begin
                va_next = v_rd_reg;
                v_raddr = y;
            end
            UOP_RD0: begin
                vb_next = v_rd_reg;
                v_raddr = 4'd0;
            end
            UOP_EXEC: begin
                cnt_next = '0;
                hit_next = 1'b0;
                case (op_reg[15:12])
                    4'h0: begin
                        if (op_reg == 16'h00EE) begin
                            sp_next = sp_dec;
                            pc_next = stk_array[sp_dec];
                        end
                    end
                    4'h1: pc_next = op_reg[11:0];
                    4'h2: begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = op_reg[11:0];
                    end
                    4'h3: if (va_reg == kk) pc_next = pc_reg + 12'd2;
                    4'h4: if (va_reg != kk) pc_next = pc_reg + 12'd2;
                    4'h5: if (va_reg == vb_reg) pc_next = pc_reg + 12'd2;
                    4'h6: begin v_we = 1'b1; v_wdata = kk; end
                    4'h7: begin v_we = 1'b1; v_wdata = va_reg + kk; end
                    4'h8: begin
                        case (n)
                            4'h0: begin v_we = 1'b1; v_wdata = vb_reg; end
                            4'h1: begin v_we = 1'b1; v_wdata = va_reg | vb_reg; end
                            4'h2: begin v_we = 1'b1; v_wdata = va_reg & vb_reg; end
                            4'h3: begin v_we = 1'b1; v_wdata = va_reg ^ vb_reg; end
                            4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, alu_flag};
                                res_next = alu_res;
                            end
                            default: ;
                        endcase
                    end
                    4'h9: if (va_reg != vb_reg) pc_next = pc_reg + 12'd2;
                    4'hA: i_next = op_reg[11:0];
                    4'hB: pc_next = op_reg[11:0] + {4'd0, v_rd_reg};
                    4'hC: begin v_we = 1'b1; v_wdata = in_rnd_reg & kk; end
                    4'hE: begin
                        if (kk == 8'h9E && key_hit) pc_next = pc_reg + 12'd2;
                        else if (kk == 8'hA1 && !key_hit) pc_next = pc_reg + 12'd2;
                    end
                    4'hF: begin
                        case (kk)
                            8'h07: begin v_we = 1'b1; v_wdata = dt_reg; end
                            8'h0A: begin
                                if (key_any) begin
                                    v_we = 1'b1; v_wdata = {4'd0, key_idx};
                                end else begin
                                    pc_next = pc_reg - 12'd2;
                                    wait_next = 1'b1;
                                end
                            end
                            8'h15: dt_next = va_reg;
                            8'h18: st_next = va_reg;
                            8'h1E: i_next = i_reg + {4'd0, va_reg};
                            8'h29: i_next = FONT_BASE + ({4'd0, va_reg} << 2) + {4'd0, va_reg};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            UOP_WRX: begin
                v_we = 1'b1; v_wdata = res_reg;
            end
            UOP_CLS: begin
                if (fb_row != '0) chg_next = 1'b1;
                fb_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_DR_RD: mem_raddr = i_off;
            UOP_DR_WR: begin
                fb_ridx  = vb_reg[ROW_W-1:0] + cnt_reg[ROW_W-1:0];
                fb_widx  = fb_ridx;
                fb_we    = 1'b1;
                fb_wdata = fb_row ^ spr_mask;
                if ((fb_row & spr_mask) != '0) hit_next = 1'b1;
                if (spr_mask != '0) chg_next = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_DR_VF: begin
                v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, hit_reg};
            end
            UOP_BCD: begin
                mem_we = 1'b1; mem_wdata = bcd_digit;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_ST_RD: v_raddr = cnt_reg[3:0];
            UOP_ST_WR: begin
                mem_we = 1'b1; mem_wdata = v_rd_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_LD_RD: mem_raddr = i_off;
            UOP_LD_WR: begin
                v_we = 1'b1; v_waddr = cnt_reg[3:0]; v_wdata = mem_rd_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_DONE: begin
                if (tick && dt_reg != 8'd0) dt_next = dt_reg - 8'd1;
                if (tick && st_reg != 8'd0) st_next = st_reg - 8'd1;
                m_valid_next = 1'b1;
            end
            default: ;
        endcase

        if (cfg_we) pc_next = cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= RESET_PC;
            i_reg       <= '0;
            sp_reg      <= '0;
            dt_reg      <= '0;
            st_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < STACK_DEPTH; k++) stk_array[k] <= '0;
        end else begin
            pc_reg      <= pc_next;
            i_reg       <= i_next;
            sp_reg      <= sp_next;
            dt_reg      <= dt_next;
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (stk_we) stk_array[sp_reg] <= pc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        va_reg   <= va_next;
        vb_reg   <= vb_next;
        res_reg  <= res_next;
        hit_reg  <= hit_next;
        chg_reg  <= chg_next;
        wait_reg <= wait_next;
        row_reg  <= row_next;
        if (cmd.accept) begin
            in_op_reg    <= s_tuser;
            in_addr_reg  <= s_tdata[11:0];
            in_wdata_reg <= s_tdata[19:12];
            in_keys_reg  <= s_tdata[35:20];
            in_rnd_reg   <= s_tdata[43:36];
        end
        if (cmd.uop == UOP_DONE) begin
            out_row     <= row_reg;
            out_pc      <= pc_reg;
            out_opcode  <= op_reg;
            out_sound   <= (st_next != 8'd0);
            out_wait    <= wait_reg;
            out_changed <= chg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem_array[mem_waddr] <= mem_wdata;
        mem_rd_reg <= mem_array[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (v_we) vreg_array[v_waddr] <= v_wdata;
        v_rd_reg <= vreg_array[v_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fb_we) fb_array[fb_widx] <= fb_wdata;
    end

    assign m_tvalid = m_valid_reg;

endmodule

@@ src/chip8_cpu_core_unit.sv @@
// sequence: write or row read then done; execute fetches opcode, reads vx, vy, v0,
// executes, then alu flag op writes vx, clear walks all rows, draw reads and writes
// each row then sets vf, bcd writes each digit, store or load moves v0 through vx;
// throughput: one word at a time, next word taken once the previous leaves done
// reset: synchronous, active low; a clearing pass over all of memory loads the font and
// zeroes memory, registers and display before the first word is taken
module chip8_cpu_core_unit import c8cpu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // address[11:0], write_data[19:12], key_state[35:20], random_byte[43:36]
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]          s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // row_pixels[63:0], program_counter[75:64], executed_opcode[91:76],
    // sound_on[92], waiting_key[93], frame_changed[94]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cmd_t  cmd;
    stat_t stat;
    logic [ADDR_W-1:0] start_reg;
    logic              cfg_we;
    logic [SCREEN_WIDTH-1:0] out_row;
    logic [ADDR_W-1:0] out_pc;
    logic [15:0]       out_opcode;
    logic              out_sound, out_wait, out_changed;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {20'd0, start_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= RESET_PC;
        end else if (cfg_we) begin
            start_reg <= pwdata[ADDR_W-1:0];
        end
    end

    c8cpu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    c8cpu_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .cfg_we      (cfg_we),
        .cfg_data    (pwdata[ADDR_W-1:0]),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .out_row     (out_row),
        .out_pc      (out_pc),
        .out_opcode  (out_opcode),
        .out_sound   (out_sound),
        .out_wait    (out_wait),
        .out_changed (out_changed)
    );

    assign m_tdata = {1'b0, out_changed, out_wait, out_sound, out_opcode, out_pc, out_row};

endmodule
